// ===== hdl/cbms_pkg.sv =====
package cbms_pkg;

   // Matrix geometry and modulation depth.
   localparam int MATRIX_SIZE = 15;
   localparam int PLANE_COUNT = 8;
   localparam int PIXEL_TOTAL = MATRIX_SIZE * MATRIX_SIZE;

   // Field widths of the transaction payloads.
   localparam int ADDR_W   = 8;
   localparam int PIXEL_W  = 8;
   localparam int BRIGHT_W = 7;
   localparam int ROW_W    = 4;
   localparam int PLANE_W  = 3;
   localparam int DWELL_W  = 10;
   localparam int PIN_W    = 16;
   localparam int COL_W    = $clog2(MATRIX_SIZE);

   localparam int ROW_PIN_BIT = 15;
   localparam int DWELL_BASE  = 4;
   localparam int FULL_SCALE  = 100;

   // Division by FULL_SCALE as a multiply by a scaled reciprocal. The product
   // of pixel and brightness stays below 2**15, where this is exact.
   localparam int SCALE_W      = PIXEL_W + BRIGHT_W;
   localparam int RECIP_SHIFT  = 19;
   localparam int RECIP_MULT   = ((1 << RECIP_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
   localparam int RECIP_W      = 13;
   localparam int RECIP_PROD_W = SCALE_W + RECIP_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef enum logic {
      KIND_WRITE,
      KIND_SCAN
   } cbms_kind_type;

   typedef struct packed {
      cbms_kind_type        kind;
      logic [ADDR_W-1:0]    addr;
      logic [PIXEL_W-1:0]   value;
      logic [ROW_W-1:0]     row;
      logic [PLANE_W-1:0]   plane;
   } cbms_cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_GATHER,
      BACK_FINISH,
      BACK_EMIT
   } cbms_back_state_type;

endpackage

// ===== hdl/cbms_front.sv =====
module cbms_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [cbms_pkg::ADDR_W-1:0]       req_pixel_index,
   input  logic [cbms_pkg::PIXEL_W-1:0]      req_pixel_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cbms_pkg::BRIGHT_W-1:0]     csr_brightness,
   output logic                              push_valid,
   input  logic                              push_ready,
   output cbms_pkg::cbms_cmd_type            push_cmd
);

   logic [cbms_pkg::BRIGHT_W-1:0]     bright_ff;
   logic [cbms_pkg::BRIGHT_W-1:0]     bright_clamped;
   logic [cbms_pkg::DWELL_W-1:0]      dwell_ff;
   logic [cbms_pkg::DWELL_W-1:0]      dwell_in;
   logic [cbms_pkg::ROW_W-1:0]        row_ff;
   logic [cbms_pkg::ROW_W-1:0]        row_in;
   logic [cbms_pkg::PLANE_W-1:0]      plane_ff;
   logic [cbms_pkg::PLANE_W-1:0]      plane_in;
   logic                              stage_valid_ff;
   logic                              stage_valid_in;
   cbms_pkg::cbms_kind_type           stage_kind_ff;
   logic [cbms_pkg::ADDR_W-1:0]       stage_addr_ff;
   logic [cbms_pkg::SCALE_W-1:0]      stage_prod_ff;
   logic [cbms_pkg::ROW_W-1:0]        stage_row_ff;
   logic [cbms_pkg::PLANE_W-1:0]      stage_plane_ff;
   logic [cbms_pkg::SCALE_W-1:0]      prod_in;
   logic [cbms_pkg::RECIP_PROD_W-1:0] recip_prod;
   logic                              accept;
   logic                              is_write;
   logic                              expire;
   logic                              keep;

   assign csr_ready = 1'b1;

   always_comb begin
      bright_clamped = (bright_ff > cbms_pkg::BRIGHT_W'(cbms_pkg::FULL_SCALE)) ?
                       cbms_pkg::BRIGHT_W'(cbms_pkg::FULL_SCALE) : bright_ff;
      req_ready  = !stage_valid_ff || push_ready;
      accept     = req_valid && req_ready;
      is_write   = (req_operation == cbms_pkg::OP_WRITE);
      expire     = (dwell_ff <= cbms_pkg::DWELL_W'(1));
      keep       = is_write ? (req_pixel_index < cbms_pkg::ADDR_W'(cbms_pkg::PIXEL_TOTAL))
                            : expire;
      prod_in    = cbms_pkg::SCALE_W'(req_pixel_value) *
                   cbms_pkg::SCALE_W'(bright_clamped);
      stage_valid_in = (stage_valid_ff && !push_ready) || (accept && keep);

      // Scan position advances at accept time, so the front end alone decides
      // which ticks open a new slot.
      dwell_in = dwell_ff;
      row_in   = row_ff;
      plane_in = plane_ff;
      if (accept && !is_write) begin
         if (expire) begin
            dwell_in = cbms_pkg::DWELL_W'(cbms_pkg::DWELL_BASE) << plane_ff;
            if (row_ff == cbms_pkg::ROW_W'(cbms_pkg::MATRIX_SIZE - 1)) begin
               row_in   = '0;
               plane_in = (plane_ff == cbms_pkg::PLANE_W'(cbms_pkg::PLANE_COUNT - 1)) ?
                          '0 : plane_ff + 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            dwell_in = dwell_ff - 1'b1;
         end
      end

      recip_prod       = cbms_pkg::RECIP_PROD_W'(stage_prod_ff) *
                         cbms_pkg::RECIP_PROD_W'(cbms_pkg::RECIP_MULT);
      push_valid       = stage_valid_ff;
      push_cmd.kind    = stage_kind_ff;
      push_cmd.addr    = stage_addr_ff;
      push_cmd.value   = cbms_pkg::PIXEL_W'(recip_prod >> cbms_pkg::RECIP_SHIFT);
      push_cmd.row     = stage_row_ff;
      push_cmd.plane   = stage_plane_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff      <= cbms_pkg::BRIGHT_W'(cbms_pkg::FULL_SCALE);
         dwell_ff       <= cbms_pkg::DWELL_W'(cbms_pkg::DWELL_BASE);
         row_ff         <= '0;
         plane_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            bright_ff <= csr_brightness;
         end
         dwell_ff       <= dwell_in;
         row_ff         <= row_in;
         plane_ff       <= plane_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         stage_kind_ff  <= is_write ? cbms_pkg::KIND_WRITE : cbms_pkg::KIND_SCAN;
         stage_addr_ff  <= req_pixel_index;
         stage_prod_ff  <= prod_in;
         stage_row_ff   <= row_ff;
         stage_plane_ff <= plane_ff;
      end
   end

endmodule

// ===== hdl/cbms_cmd_queue.sv =====
module cbms_cmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  cbms_pkg::cbms_cmd_type push_cmd,
   output logic                   pop_valid,
   input  logic                   pop,
   output cbms_pkg::cbms_cmd_type pop_cmd
);

   cbms_pkg::cbms_cmd_type          slot_ff [cbms_pkg::QUEUE_DEPTH];
   logic [cbms_pkg::QPTR_W-1:0]     wr_ptr_ff;
   logic [cbms_pkg::QPTR_W-1:0]     rd_ptr_ff;
   logic [cbms_pkg::QCNT_W-1:0]     count_ff;
   logic [cbms_pkg::QCNT_W-1:0]     count_in;
   logic                            do_push;
   logic                            do_pop;

   always_comb begin
      push_ready = (count_ff != cbms_pkg::QCNT_W'(cbms_pkg::QUEUE_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_cmd    = slot_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop && pop_valid;
      count_in   = count_ff + cbms_pkg::QCNT_W'(do_push) - cbms_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/cbms_back.sv =====
module cbms_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_pop,
   input  cbms_pkg::cbms_cmd_type        cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cbms_pkg::PIN_W-1:0]    rsp_pin_level,
   output logic [cbms_pkg::PIN_W-1:0]    rsp_pin_output_enable,
   output logic [cbms_pkg::ROW_W-1:0]    rsp_scan_row_shown,
   output logic [cbms_pkg::PLANE_W-1:0]  rsp_bit_plane_shown,
   output logic [cbms_pkg::DWELL_W-1:0]  rsp_dwell_ticks
);

   cbms_pkg::cbms_back_state_type     state_ff;
   cbms_pkg::cbms_back_state_type     state_in;

   logic [cbms_pkg::PIXEL_W-1:0]      mem [cbms_pkg::PIXEL_TOTAL];
   logic [cbms_pkg::PIXEL_TOTAL-1:0]  pix_valid_ff;

   logic [cbms_pkg::ROW_W-1:0]        row_ff;
   logic [cbms_pkg::PLANE_W-1:0]      plane_ff;
   logic [cbms_pkg::ADDR_W-1:0]       addr_ff;
   logic [cbms_pkg::COL_W-1:0]        col_ff;
   logic [cbms_pkg::COL_W-1:0]        rd_col_ff;
   logic                              rd_pend_ff;
   logic [cbms_pkg::PIXEL_W-1:0]      rd_data_ff;
   logic                              rd_valid_ff;
   logic [cbms_pkg::MATRIX_SIZE-1:0]  bits_ff;
   logic [cbms_pkg::ADDR_W-1:0]       base_addr;

   logic                              mem_we;
   logic                              start_scan;
   logic                              issue;
   logic                              load_rsp;

   logic [cbms_pkg::MATRIX_SIZE-1:0]  row_mask;
   logic                              row_lit;
   logic [cbms_pkg::PIN_W-1:0]        level;
   logic [cbms_pkg::PIN_W-1:0]        enable;

   logic                              rsp_valid_ff;
   logic [cbms_pkg::PIN_W-1:0]        rsp_level_ff;
   logic [cbms_pkg::PIN_W-1:0]        rsp_enable_ff;
   logic [cbms_pkg::ROW_W-1:0]        rsp_row_ff;
   logic [cbms_pkg::PLANE_W-1:0]      rsp_plane_ff;
   logic [cbms_pkg::DWELL_W-1:0]      rsp_dwell_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbms_pkg::BACK_IDLE: begin
            if (cmd_valid && (cmd.kind == cbms_pkg::KIND_SCAN)) begin
               state_in = cbms_pkg::BACK_GATHER;
            end
         end
         cbms_pkg::BACK_GATHER: begin
            if (col_ff == cbms_pkg::COL_W'(cbms_pkg::MATRIX_SIZE - 1)) begin
               state_in = cbms_pkg::BACK_FINISH;
            end
         end
         cbms_pkg::BACK_FINISH: begin
            state_in = cbms_pkg::BACK_EMIT;
         end
         cbms_pkg::BACK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = cbms_pkg::BACK_IDLE;
            end
         end
         default: state_in = cbms_pkg::BACK_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      cmd_pop    = (state_ff == cbms_pkg::BACK_IDLE) && cmd_valid;
      mem_we     = cmd_pop && (cmd.kind == cbms_pkg::KIND_WRITE);
      start_scan = cmd_pop && (cmd.kind == cbms_pkg::KIND_SCAN);
      issue      = (state_ff == cbms_pkg::BACK_GATHER);
      load_rsp   = (state_ff == cbms_pkg::BACK_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   // Scan row r shows framebuffer row (MATRIX_SIZE - 1 - r).
   always_comb begin
      base_addr = (cbms_pkg::ADDR_W'(cbms_pkg::MATRIX_SIZE - 1) -
                   cbms_pkg::ADDR_W'(cmd.row)) *
                  cbms_pkg::ADDR_W'(cbms_pkg::MATRIX_SIZE);
      row_mask  = cbms_pkg::MATRIX_SIZE'(1) << row_ff;
      row_lit   = |(bits_ff & row_mask);
      level     = cbms_pkg::PIN_W'(bits_ff & ~row_mask) |
                  (cbms_pkg::PIN_W'(row_lit) << cbms_pkg::ROW_PIN_BIT);
      enable    = level | cbms_pkg::PIN_W'(row_mask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbms_pkg::BACK_IDLE;
         pix_valid_ff <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= issue;
         if (mem_we) begin
            pix_valid_ff[cmd.addr] <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd.addr] <= cmd.value;
      end
      if (issue) begin
         rd_data_ff  <= mem[addr_ff];
         rd_valid_ff <= pix_valid_ff[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (start_scan) begin
         row_ff   <= cmd.row;
         plane_ff <= cmd.plane;
         addr_ff  <= base_addr;
         col_ff   <= '0;
         bits_ff  <= '0;
      end else begin
         if (issue) begin
            addr_ff   <= addr_ff + 1'b1;
            col_ff    <= col_ff + 1'b1;
            rd_col_ff <= col_ff;
         end
         if (rd_pend_ff) begin
            bits_ff[rd_col_ff] <= rd_valid_ff & rd_data_ff[plane_ff];
         end
      end
      if (load_rsp) begin
         rsp_level_ff  <= level;
         rsp_enable_ff <= enable;
         rsp_row_ff    <= row_ff;
         rsp_plane_ff  <= plane_ff;
         rsp_dwell_ff  <= cbms_pkg::DWELL_W'(cbms_pkg::DWELL_BASE) << plane_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pin_level         = rsp_level_ff;
   assign rsp_pin_output_enable = rsp_enable_ff;
   assign rsp_scan_row_shown    = rsp_row_ff;
   assign rsp_bit_plane_shown   = rsp_plane_ff;
   assign rsp_dwell_ticks       = rsp_dwell_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == cbms_pkg::BACK_EMIT))
      else $error("response raised outside the emit step");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbms_pkg::BACK_GATHER) |->
         (col_ff < cbms_pkg::COL_W'(cbms_pkg::MATRIX_SIZE)))
      else $error("column counter ran past the matrix");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (cmd.addr < cbms_pkg::ADDR_W'(cbms_pkg::PIXEL_TOTAL)))
      else $error("pixel write beyond the framebuffer");

   a_finish_after_gather: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbms_pkg::BACK_FINISH) |->
         ($past(state_ff) == cbms_pkg::BACK_GATHER))
      else $error("gather did not precede finish");

endmodule

// ===== hdl/charlieplex_bcm_matrix_scan.sv =====
// Charlieplexed 15x15 LED matrix scanner with binary code modulation.
// The req_ channel carries one transaction per pixel write or microsecond tick.
// A pixel write stores value * brightness / 100 into the framebuffer; a tick
// counts down the dwell and, when it expires, opens a new row / bit-plane slot.
// Each opened slot produces one rsp_ transaction with the pin level and
// output-enable masks, the row, the plane and the dwell length of that slot.
// The csr_ channel writes the brightness percentage; it is always ready and
// affects only pixels written afterwards.
// The front end takes one transaction per cycle while its stage and the
// four-entry command queue have room. In the back end a pixel write is stored
// straight from the idle state; a slot walks the gather, finish and emit states,
// reading fifteen pixels through the single framebuffer read port, and pops no
// new command until it is done. A stalled rsp_ready holds the result register
// and stops only the back end; the queue keeps absorbing up to four writes or
// slots meanwhile. Reset clears the framebuffer through per-pixel valid flags,
// sets brightness to 100, the dwell to 4 and the scan to row 0, plane 0.
module charlieplex_bcm_matrix_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [cbms_pkg::ADDR_W-1:0]   req_pixel_index,
   input  logic [cbms_pkg::PIXEL_W-1:0]  req_pixel_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cbms_pkg::PIN_W-1:0]    rsp_pin_level,
   output logic [cbms_pkg::PIN_W-1:0]    rsp_pin_output_enable,
   output logic [cbms_pkg::ROW_W-1:0]    rsp_scan_row_shown,
   output logic [cbms_pkg::PLANE_W-1:0]  rsp_bit_plane_shown,
   output logic [cbms_pkg::DWELL_W-1:0]  rsp_dwell_ticks,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cbms_pkg::BRIGHT_W-1:0] csr_brightness
);

   // Commands flow from the classifying front end through a short queue to the
   // back end, which owns the framebuffer and the result register.
   logic                   push_valid;
   logic                   push_ready;
   cbms_pkg::cbms_cmd_type push_cmd;
   logic                   pop_valid;
   logic                   pop;
   cbms_pkg::cbms_cmd_type pop_cmd;

   // The front end keeps the dwell counter and scan position, so it alone
   // decides which ticks open a slot; other ticks never reach the queue.
   cbms_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_pixel_index (req_pixel_index),
      .req_pixel_value (req_pixel_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_brightness  (csr_brightness),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_cmd        (push_cmd)
   );

   cbms_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   // Writes and slots leave the queue in order, so every slot sees exactly the
   // pixels written before its tick.
   cbms_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cmd_valid             (pop_valid),
      .cmd_pop               (pop),
      .cmd                   (pop_cmd),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_pin_level         (rsp_pin_level),
      .rsp_pin_output_enable (rsp_pin_output_enable),
      .rsp_scan_row_shown    (rsp_scan_row_shown),
      .rsp_bit_plane_shown   (rsp_bit_plane_shown),
      .rsp_dwell_ticks       (rsp_dwell_ticks)
   );

endmodule

// ===== tb/sv/charlieplex_bcm_matrix_scan_tb.sv =====
`timescale 1ns / 1ps

module charlieplex_bcm_matrix_scan_tb;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 8;
   // The command queue holds four entries and each queued slot passes through
   // the back end in turn; the drain lets any queued pixel write finish.
   localparam int DRAIN_CYCLES = 100;
   // Cycles with no transaction on any channel before the run is abandoned.
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 112;
   localparam int PHASE_COUNT  = 7;
   localparam int DIR_ROWS     = 16;
   localparam int REPORT_CAP   = 200;

   // One displayed slot, as the result channel carries it.
   typedef struct packed {
      logic [cbms_pkg::PIN_W-1:0]   level;
      logic [cbms_pkg::PIN_W-1:0]   enable;
      logic [cbms_pkg::ROW_W-1:0]   row;
      logic [cbms_pkg::PLANE_W-1:0] plane;
      logic [cbms_pkg::DWELL_W-1:0] dwell;
   } slot_type;

   // One row of the directed stimulus. When hand_set is high the row is a tick
   // whose slot is written out by hand in want; otherwise the predictor decides.
   typedef struct {
      logic                         op;
      logic [cbms_pkg::ADDR_W-1:0]  idx;
      logic [cbms_pkg::PIXEL_W-1:0] val;
      logic                         hand_set;
      slot_type                     want;
   } dir_row_type;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_operation   = cbms_pkg::OP_WRITE;
   logic [cbms_pkg::ADDR_W-1:0]   req_pixel_index = '0;
   logic [cbms_pkg::PIXEL_W-1:0]  req_pixel_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [cbms_pkg::PIN_W-1:0]    rsp_pin_level;
   logic [cbms_pkg::PIN_W-1:0]    rsp_pin_output_enable;
   logic [cbms_pkg::ROW_W-1:0]    rsp_scan_row_shown;
   logic [cbms_pkg::PLANE_W-1:0]  rsp_bit_plane_shown;
   logic [cbms_pkg::DWELL_W-1:0]  rsp_dwell_ticks;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [cbms_pkg::BRIGHT_W-1:0] csr_brightness = '0;

   // Shadow of the block's state, advanced at every accepted transaction.
   logic [cbms_pkg::PIXEL_W-1:0]  frame_copy [cbms_pkg::PIXEL_TOTAL];
   logic [cbms_pkg::ROW_W-1:0]    row_next;
   logic [cbms_pkg::PLANE_W-1:0]  plane_next;
   logic [cbms_pkg::DWELL_W-1:0]  dwell_left;
   logic [cbms_pkg::BRIGHT_W-1:0] bright_pct;

   slot_type    slot_expected_q [$];
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned err_count     = 0;
   int unsigned write_count   = 0;
   int unsigned tick_count    = 0;
   int unsigned slot_count    = 0;
   int unsigned idle_cycles   = 0;
   logic [cbms_pkg::PLANE_COUNT-1:0] planes_seen = '0;

   // Directed part. The two hand-written slots follow from the writes above
   // them: scan row 0 shows framebuffer row 14 (pixels 210..224) and scan row 1
   // shows framebuffer row 13 (pixels 195..209). A lit pixel in the column that
   // equals the scan row lands on the row pin bit 15 instead, and the row's own
   // cathode bit is always enabled. Indexes 225 and 255 lie past the matrix and
   // must leave the framebuffer alone.
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{cbms_pkg::OP_WRITE, 8'd210, 8'd255, 1'b0, '0},
      '{cbms_pkg::OP_WRITE, 8'd224, 8'd255, 1'b0, '0},
      '{cbms_pkg::OP_WRITE, 8'd225, 8'd255, 1'b0, '0},
      '{cbms_pkg::OP_WRITE, 8'd255, 8'd255, 1'b0, '0},
      '{cbms_pkg::OP_WRITE, 8'd0,   8'd0,   1'b0, '0},
      '{cbms_pkg::OP_WRITE, 8'd196, 8'd1,   1'b0, '0},
      '{cbms_pkg::OP_WRITE, 8'd200, 8'd254, 1'b0, '0},
      '{cbms_pkg::OP_WRITE, 8'd195, 8'd128, 1'b0, '0},
      '{cbms_pkg::OP_TICK,  8'd0,   8'd0,   1'b0, '0},
      '{cbms_pkg::OP_TICK,  8'd255, 8'd255, 1'b0, '0},
      '{cbms_pkg::OP_TICK,  8'd0,   8'd0,   1'b0, '0},
      '{cbms_pkg::OP_TICK,  8'd0,   8'd0,   1'b1,
        '{16'hC000, 16'hC001, 4'd0, 3'd0, 10'd4}},
      '{cbms_pkg::OP_TICK,  8'd0,   8'd0,   1'b0, '0},
      '{cbms_pkg::OP_TICK,  8'd0,   8'd0,   1'b0, '0},
      '{cbms_pkg::OP_TICK,  8'd0,   8'd0,   1'b0, '0},
      '{cbms_pkg::OP_TICK,  8'd0,   8'd0,   1'b1,
        '{16'h8000, 16'h8002, 4'd1, 3'd0, 10'd4}}
   };

   charlieplex_bcm_matrix_scan u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_pixel_index       (req_pixel_index),
      .req_pixel_value       (req_pixel_value),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_pin_level         (rsp_pin_level),
      .rsp_pin_output_enable (rsp_pin_output_enable),
      .rsp_scan_row_shown    (rsp_scan_row_shown),
      .rsp_bit_plane_shown   (rsp_bit_plane_shown),
      .rsp_dwell_ticks       (rsp_dwell_ticks),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_brightness        (csr_brightness)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Applies one accepted request to the shadow state. Returns 1 and the slot
   // when a tick expires the dwell; pixel writes and other ticks return 0.
   function automatic logic scan_predict(input logic op,
                                         input logic [cbms_pkg::ADDR_W-1:0] idx,
                                         input logic [cbms_pkg::PIXEL_W-1:0] val,
                                         output slot_type slot);
      int unsigned pct;
      int unsigned base;
      int          x;
      logic [cbms_pkg::PIN_W-1:0] cols;
      slot = '0;
      if (op == cbms_pkg::OP_WRITE) begin
         // Brightness above full scale is clamped to full scale.
         pct = (bright_pct > cbms_pkg::FULL_SCALE) ? cbms_pkg::FULL_SCALE : bright_pct;
         if (idx < cbms_pkg::PIXEL_TOTAL) begin
            frame_copy[idx] = cbms_pkg::PIXEL_W'((val * pct) / cbms_pkg::FULL_SCALE);
         end
         return 1'b0;
      end
      if (dwell_left > 1) begin
         dwell_left = dwell_left - 1'b1;
         return 1'b0;
      end
      // The scan runs bottom-up through the framebuffer rows.
      base = (cbms_pkg::MATRIX_SIZE - 1 - row_next) * cbms_pkg::MATRIX_SIZE;
      cols = '0;
      for (x = 0; x < cbms_pkg::MATRIX_SIZE; x++) begin
         cols[x] = frame_copy[base + x][plane_next];
      end
      slot.level = cols;
      slot.level[cbms_pkg::ROW_PIN_BIT] = cols[row_next];
      slot.level[row_next] = 1'b0;
      slot.enable = slot.level;
      slot.enable[row_next] = 1'b1;
      slot.row = row_next;
      slot.plane = plane_next;
      slot.dwell = cbms_pkg::DWELL_W'(cbms_pkg::DWELL_BASE << plane_next);
      dwell_left = slot.dwell;
      if (row_next == cbms_pkg::MATRIX_SIZE - 1) begin
         row_next = '0;
         plane_next = (plane_next == cbms_pkg::PLANE_COUNT - 1) ? '0 : plane_next + 1'b1;
      end else begin
         row_next = row_next + 1'b1;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      if (err_count < REPORT_CAP) begin
         $display("%0d ns: mismatch: %s", $time, what);
      end
      err_count++;
   endtask

   // Presents one request transaction, starting and ending at a falling edge.
   // Valid is left high on return so back-to-back requests need no gap; the
   // caller or the next call lowers it.
   task automatic send_req(input logic op, input logic [cbms_pkg::ADDR_W-1:0] idx,
                           input logic [cbms_pkg::PIXEL_W-1:0] val, input logic hand_set,
                           input slot_type want);
      slot_type slot;
      logic     fired;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_pixel_index <= idx;
      req_pixel_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      fired = scan_predict(op, idx, val, slot);
      if (hand_set) begin
         slot_expected_q.push_back(want);
      end else if (fired) begin
         slot_expected_q.push_back(slot);
      end
      if (op == cbms_pkg::OP_TICK) tick_count++;
      else write_count++;
      @(negedge clock);
   endtask

   task automatic send_random(input int unsigned tick_pct);
      logic                         op;
      logic [cbms_pkg::ADDR_W-1:0]  idx;
      logic [cbms_pkg::PIXEL_W-1:0] val;
      op = ($urandom_range(99) < tick_pct) ? cbms_pkg::OP_TICK : cbms_pkg::OP_WRITE;
      // Mostly valid pixels, now and then an index past the matrix.
      idx = ($urandom_range(15) == 0) ?
            cbms_pkg::ADDR_W'($urandom) :
            cbms_pkg::ADDR_W'($urandom_range(cbms_pkg::PIXEL_TOTAL - 1));
      case ($urandom_range(7))
         0: val = '0;
         1: val = '1;
         default: val = cbms_pkg::PIXEL_W'($urandom);
      endcase
      send_req(op, idx, val, 1'b0, '0);
   endtask

   // Holds the request channel idle until every expected slot has come back.
   task automatic wait_results;
      req_valid <= 1'b0;
      do @(negedge clock); while (slot_expected_q.size() != 0);
   endtask

   task automatic write_brightness(input logic [cbms_pkg::BRIGHT_W-1:0] pct);
      csr_valid      <= 1'b1;
      csr_brightness <= pct;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      bright_pct = pct;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // The receiver stalls at random; rsp_stall_pct of zero keeps it always ready.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Every accepted result is checked field by field against the oldest
   // expected slot.
   always @(posedge clock) begin
      slot_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         slot_count++;
         planes_seen[rsp_bit_plane_shown] = 1'b1;
         if (slot_expected_q.size() == 0) begin
            report_mismatch($sformatf("result with none expected (row %0d plane %0d)",
                                      rsp_scan_row_shown, rsp_bit_plane_shown));
         end else begin
            want = slot_expected_q.pop_front();
            if (rsp_pin_level !== want.level)
               report_mismatch($sformatf("pin_level %h, expected %h",
                                         rsp_pin_level, want.level));
            if (rsp_pin_output_enable !== want.enable)
               report_mismatch($sformatf("pin_output_enable %h, expected %h",
                                         rsp_pin_output_enable, want.enable));
            if (rsp_scan_row_shown !== want.row)
               report_mismatch($sformatf("scan_row_shown %0d, expected %0d",
                                         rsp_scan_row_shown, want.row));
            if (rsp_bit_plane_shown !== want.plane)
               report_mismatch($sformatf("bit_plane_shown %0d, expected %0d",
                                         rsp_bit_plane_shown, want.plane));
            if (rsp_dwell_ticks !== want.dwell)
               report_mismatch($sformatf("dwell_ticks %0d, expected %0d",
                                         rsp_dwell_ticks, want.dwell));
         end
      end
   end

   // Watchdog: any transaction on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d slots outstanding.",
                  STALL_LIMIT, slot_expected_q.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned phase_bright [PHASE_COUNT];
      int unsigned phase_send   [PHASE_COUNT];
      int unsigned phase_stall  [PHASE_COUNT];
      int unsigned ph;
      int unsigned n;

      // Brightness settings per phase: the extremes, the reset value, values
      // above full scale that must clamp, and random ones.
      phase_bright = '{0, 127, 100, 1, 101, $urandom_range(127), $urandom_range(100)};
      // Idle mix per phase, in percent: sender gaps and receiver stalls.
      phase_send   = '{0, 67, 0, 24, 0, 24, 0};
      phase_stall  = '{0, 0, 67, 24, 0, 24, 0};

      // Shadow state after reset.
      foreach (frame_copy[i]) frame_copy[i] = '0;
      row_next   = '0;
      plane_next = '0;
      dwell_left = cbms_pkg::DWELL_W'(cbms_pkg::DWELL_BASE);
      bright_pct = cbms_pkg::BRIGHT_W'(cbms_pkg::FULL_SCALE);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows run at the reset brightness with no idling.
      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val,
                  dir_rows[i].hand_set, dir_rows[i].want);
      end

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         // The brightness register is only written with the block idle: all
         // slots returned, then time for queued pixel writes to retire.
         wait_results();
         repeat (DRAIN_CYCLES) @(negedge clock);
         write_brightness(cbms_pkg::BRIGHT_W'(phase_bright[ph]));
         send_idle_pct = phase_send[ph];
         rsp_stall_pct = phase_stall[ph];

         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Once, halfway through the stalled-receiver phase, the sender
            // holds off until the block has returned every slot.
            if (ph == 2 && n == PHASE_ITEMS / 2) wait_results();
            // The last phase is mostly ticks, pushing the scan into the
            // higher bit planes with a populated framebuffer.
            send_random((ph == PHASE_COUNT - 1) ? 97 : 50);
         end
      end

      wait_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d pixel writes and %0d ticks in %0d idle phases, %0d slots.",
               write_count, tick_count, PHASE_COUNT, slot_count);
      $display("Bit planes shown %b; brightness 0, 100 and clamped values above 100.",
               planes_seen);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cbms_pkg.sv
hdl/cbms_front.sv
hdl/cbms_cmd_queue.sv
hdl/cbms_back.sv
hdl/charlieplex_bcm_matrix_scan.sv
tb/sv/charlieplex_bcm_matrix_scan_tb.sv
